FILE: rtl/divide_64_by_32_restoring_assert.svh
// assertion macros for the 64-by-32 restoring divider
// used by the top level only, no other dependencies
`ifndef DIVIDE_64_BY_32_RESTORING_ASSERT_SVH
`define DIVIDE_64_BY_32_RESTORING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DIV64_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("divider assertion failed");

// next-cycle implication, checked outside reset
`define DIV64_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("divider assertion failed");

`endif

FILE: rtl/div64_pkg.sv
// shared widths and defaults for the 64-by-32 restoring divider
// no dependencies
package div64_pkg;

	localparam int WORD_BITS             = 32;
	localparam int QUOTIENT_BITS_DEFAULT = 32;

	typedef logic [WORD_BITS-1:0] word_t;

endpackage

FILE: rtl/div64_if.sv
// valid/ready channel interfaces for divider operands and quotient
// depends on div64_pkg
interface div64_in_if;
	logic               valid;
	logic               ready;
	div64_pkg::word_t   dividend_high;
	div64_pkg::word_t   dividend_low;
	div64_pkg::word_t   divisor;

	modport source (output valid, dividend_high, dividend_low, divisor, input ready);
	modport sink   (input valid, dividend_high, dividend_low, divisor, output ready);
endinterface

interface div64_out_if;
	logic               valid;
	logic               ready;
	div64_pkg::word_t   quotient;

	modport source (output valid, quotient, input ready);
	modport sink   (input valid, quotient, output ready);
endinterface

FILE: rtl/divide_64_by_32_restoring.sv
// channel    | dir | payload                                  | handshake
// din        | in  | dividend_high, dividend_low, divisor     | valid/ready
// dout       | out | quotient                                 | valid/ready
//
// a row of QUOTIENT_BITS cells, one quotient bit per cell; a din transfer passes
// through the cell registers in order, and dout valid rises once the last cell holds it,
// one item per cycle while dout.ready is not held low
// the last cell register is the output register; a stalled cell holds, and a
// cell accepts whenever it is empty or its neighbor takes its contents
// arst_n empties every cell; payload registers are not reset
// depends on div64_pkg, div64_if, div64_cell, divide_64_by_32_restoring_assert.svh
module divide_64_by_32_restoring #(
	parameter int QUOTIENT_BITS = div64_pkg::QUOTIENT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	div64_in_if.sink    din,
	div64_out_if.source dout
);
	import div64_pkg::*;

	`include "divide_64_by_32_restoring_assert.svh"

	logic                     up_vld  [QUOTIENT_BITS];
	logic                     up_rdy  [QUOTIENT_BITS];
	word_t                    up_rem  [QUOTIENT_BITS];
	logic [QUOTIENT_BITS-1:0] up_feed [QUOTIENT_BITS];
	word_t                    up_div  [QUOTIENT_BITS];
	logic [QUOTIENT_BITS-1:0] up_q    [QUOTIENT_BITS];
	logic                     vld_s   [QUOTIENT_BITS];
	logic                     dn_rdy  [QUOTIENT_BITS];
	word_t                    rem_s   [QUOTIENT_BITS];
	logic [QUOTIENT_BITS-1:0] feed_s  [QUOTIENT_BITS];
	word_t                    div_s   [QUOTIENT_BITS];
	logic [QUOTIENT_BITS-1:0] q_s     [QUOTIENT_BITS];

	for (genvar i = 0; i < QUOTIENT_BITS; i++) begin : g_cell
		if (i == 0) begin : g_head
			// only the top QUOTIENT_BITS bits of the low word are ever shifted in
			assign up_vld[i]  = din.valid;
			assign up_rem[i]  = din.dividend_high;
			assign up_feed[i] = din.dividend_low[WORD_BITS-1 -: QUOTIENT_BITS];
			assign up_div[i]  = din.divisor;
			assign up_q[i]    = '0;
		end else begin : g_link
			assign up_vld[i]    = vld_s[i-1];
			assign up_rem[i]    = rem_s[i-1];
			assign up_feed[i]   = feed_s[i-1];
			assign up_div[i]    = div_s[i-1];
			assign up_q[i]      = q_s[i-1];
			assign dn_rdy[i-1]  = up_rdy[i];
		end

		div64_cell #(
			.QUOTIENT_BITS(QUOTIENT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (up_vld[i]),
			.up_ready (up_rdy[i]),
			.up_rem   (up_rem[i]),
			.up_feed  (up_feed[i]),
			.up_div   (up_div[i]),
			.up_q     (up_q[i]),
			.dn_valid (vld_s[i]),
			.dn_ready (dn_rdy[i]),
			.dn_rem   (rem_s[i]),
			.dn_feed  (feed_s[i]),
			.dn_div   (div_s[i]),
			.dn_q     (q_s[i])
		);
	end

	assign dn_rdy[QUOTIENT_BITS-1] = dout.ready;
	assign din.ready               = up_rdy[0];
	assign dout.valid              = vld_s[QUOTIENT_BITS-1];
	assign dout.quotient           = word_t'(q_s[QUOTIENT_BITS-1]);

	// a transfer on din always lands in the first cell
	`DIV64_ASSERT_NEXT(a_head_fill, clk, arst_n, din.valid && din.ready, vld_s[0])
	// a waiting result is never overwritten by the cell behind it
	`DIV64_ASSERT_SAME(a_tail_hold, clk, arst_n, vld_s[QUOTIENT_BITS-1] && !dout.ready, !up_rdy[QUOTIENT_BITS-1])
	// zero divisor always takes the subtract branch
	`DIV64_ASSERT_SAME(a_zero_div, clk, arst_n, vld_s[0] && (div_s[0] == '0), q_s[0][0])

endmodule

FILE: rtl/div64_cell.sv
// one shift-and-subtract round of the restoring divider, with its own stage register
// depends on div64_pkg
module div64_cell #(
	parameter int QUOTIENT_BITS = div64_pkg::QUOTIENT_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  div64_pkg::word_t         up_rem,
	input  logic [QUOTIENT_BITS-1:0] up_feed,
	input  div64_pkg::word_t         up_div,
	input  logic [QUOTIENT_BITS-1:0] up_q,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output div64_pkg::word_t         dn_rem,
	output logic [QUOTIENT_BITS-1:0] dn_feed,
	output div64_pkg::word_t         dn_div,
	output logic [QUOTIENT_BITS-1:0] dn_q
);
	import div64_pkg::*;

	word_t                    rem_sh;
	word_t                    rem_nx;
	logic                     take;
	logic                     valid_q;
	word_t                    rem_q;
	logic [QUOTIENT_BITS-1:0] feed_q;
	word_t                    div_q;
	logic [QUOTIENT_BITS-1:0] q_q;

	// top bit of the old remainder falls off
	assign rem_sh = {up_rem[WORD_BITS-2:0], up_feed[QUOTIENT_BITS-1]};
	assign take   = (up_div <= rem_sh);
	assign rem_nx = take ? (rem_sh - up_div) : rem_sh;

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rem_q  <= rem_nx;
			feed_q <= {up_feed[QUOTIENT_BITS-2:0], 1'b0};
			div_q  <= up_div;
			q_q    <= {up_q[QUOTIENT_BITS-2:0], take};
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_feed  = feed_q;
	assign dn_div   = div_q;
	assign dn_q     = q_q;

endmodule

FILE: test/div64_quotient_checker.sv
// quotient checker for the 64-by-32 restoring divider: watches both channels,
// predicts each quotient with a shift-subtract model and compares in order
// depends on div64_pkg and div64_if
`timescale 1ns / 1ps

module div64_quotient_checker #(
	parameter int QUOTIENT_BITS = div64_pkg::QUOTIENT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	div64_in_if         din,
	div64_out_if        dout,
	output int unsigned errors,
	output int unsigned outstanding,
	output int unsigned checked
);
	import div64_pkg::*;

	word_t expected_quotients[$];

	// partial remainder is only WORD_BITS wide, a bit pushed out of its top is dropped
	function automatic word_t restoring_quotient(word_t high, word_t low, word_t divisor);
		word_t partial;
		word_t feed;
		word_t quotient;
		partial  = high;
		feed     = low;
		quotient = '0;
		for (int round = 0; round < QUOTIENT_BITS; round++) begin
			quotient = quotient << 1;
			partial  = {partial[WORD_BITS-2:0], feed[WORD_BITS-1]};
			feed     = feed << 1;
			if (divisor <= partial) begin
				partial     = partial - divisor;
				quotient[0] = 1'b1;
			end
		end
		return quotient;
	endfunction

	initial begin
		errors      = 0;
		outstanding = 0;
		checked     = 0;
	end

	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (dout.valid && dout.ready) begin
				if (expected_quotients.size() == 0) begin
					$display("%0t: quotient %h arrived with no division pending",
						$time, dout.quotient);
					errors <= errors + 1;
				end else begin
					want = expected_quotients.pop_front();
					checked <= checked + 1;
					if (dout.quotient !== want) begin
						$display("%0t: quotient mismatch: expected %h, actual %h",
							$time, want, dout.quotient);
						errors <= errors + 1;
					end
				end
			end
			if (din.valid && din.ready)
				expected_quotients.push_back(restoring_quotient(din.dividend_high,
					din.dividend_low, din.divisor));
			outstanding <= expected_quotients.size();
		end
	end

endmodule

FILE: test/tb_divide_64_by_32_restoring.sv
// testbench top for the 64-by-32 restoring divider: drives operands and output
// stalls, and gives the verdict from the checker's error and outstanding counts
// depends on div64_pkg, div64_if, divide_64_by_32_restoring, div64_quotient_checker
`timescale 1ns / 1ps

module tb_divide_64_by_32_restoring;
	import div64_pkg::*;

	localparam int QUOTIENT_BITS = QUOTIENT_BITS_DEFAULT;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int STEADY_ITEMS  = 200;
	localparam int STALL_LIMIT   = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic quiet;

	int unsigned errors;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned idle_cycles;
	int unsigned sent_exact;
	int unsigned sent_zero;
	int unsigned sent_overflow;

	div64_in_if  din();
	div64_out_if dout();

	divide_64_by_32_restoring #(
		.QUOTIENT_BITS(QUOTIENT_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout)
	);

	div64_quotient_checker #(
		.QUOTIENT_BITS(QUOTIENT_BITS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.dout       (dout),
		.errors     (errors),
		.outstanding(outstanding),
		.checked    (checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// no transfer on either channel for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// quotient side stalls in bursts; no new burst starts in a quiet stretch
	initial begin
		int unsigned stall;
		stall = 0;
		dout.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				dout.ready <= 1'b0;
				stall = stall - 1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				dout.ready <= 1'b0;
				stall = $urandom_range(1, 19) - 1;
			end else begin
				dout.ready <= 1'b1;
			end
		end
	end

	task automatic transfer_operands(input word_t high, input word_t low, input word_t divisor);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			din.valid         <= 1'b0;
			din.dividend_high <= $urandom;
			din.dividend_low  <= $urandom;
			din.divisor       <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		din.valid         <= 1'b1;
		din.dividend_high <= high;
		din.dividend_low  <= low;
		din.divisor       <= divisor;
		do @(posedge clk); while (!din.ready);
		if (divisor == 0)
			sent_zero++;
		else if (high < divisor && !divisor[WORD_BITS-1])
			sent_exact++;
		else
			sent_overflow++;
	endtask

	task automatic drain_quotients();
		@(negedge clk);
		din.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		word_t high;
		word_t low;
		word_t divisor;
		quiet             = 1'b0;
		idle_cycles       = 0;
		sent_exact        = 0;
		sent_zero         = 0;
		sent_overflow     = 0;
		din.valid         = 1'b0;
		din.dividend_high = '0;
		din.dividend_low  = '0;
		din.divisor       = '0;
		arst_n            = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// field extremes, zero divisor, exact limit and remainder overflow
		transfer_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		transfer_operands(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		transfer_operands(32'h0000_0000, 32'h1234_5678, 32'h0000_0000);
		transfer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		transfer_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		transfer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		transfer_operands(32'h7FFF_FFFE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		transfer_operands(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
		transfer_operands(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		transfer_operands(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
		transfer_operands(32'h0000_0005, 32'h0000_0000, 32'h0000_0003);
		transfer_operands(32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
		transfer_operands(32'h0000_0001, 32'h0000_0000, 32'h0000_0002);
		transfer_operands(32'h0000_0000, 32'h0000_0064, 32'h0000_0007);
		transfer_operands(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
		transfer_operands(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		transfer_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= RANDOM_ITEMS - STEADY_ITEMS) || ((i / 120) % 5 == 2);
			if (i == 500 || i == 1000)
				drain_quotients();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					// exact range, divisor magnitude spread over sizes up to 31 bits
					divisor = $urandom >> $urandom_range(1, 31);
					if (divisor == 0)
						divisor = 1;
					high = $urandom % divisor;
					low  = $urandom;
				end
				5: begin
					divisor = '0;
					high    = $urandom;
					low     = $urandom;
				end
				6: begin
					divisor = $urandom | 32'h8000_0000;
					high    = $urandom;
					low     = $urandom;
				end
				7: begin
					// high word at or above divisor
					divisor = $urandom_range(1, 32'hFFFF_FFFF);
					high    = divisor + ($urandom % ((32'hFFFF_FFFF - divisor) + 1));
					low     = $urandom;
				end
				8: begin
					divisor = $urandom;
					high    = $urandom;
					low     = $urandom;
				end
				default: begin
					divisor = $urandom_range(1, 15);
					high    = $urandom_range(0, divisor - 1);
					low     = $urandom_range(0, 255);
				end
			endcase
			transfer_operands(high, low, divisor);
		end

		@(negedge clk);
		din.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (QUOTIENT_BITS + 8) @(negedge clk);

		$display("%0d divisions: %0d exact, %0d zero divisor, %0d remainder overflow",
			sent_exact + sent_zero + sent_overflow, sent_exact, sent_zero, sent_overflow);
		$display("%0d quotients compared, %0d errors", checked, errors);
		if (errors == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/div64_pkg.sv
rtl/div64_if.sv
rtl/div64_cell.sv
rtl/divide_64_by_32_restoring.sv
test/div64_quotient_checker.sv
test/tb_divide_64_by_32_restoring.sv
